// ===== hdl/bdeq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bounded deque unit.
// No dependencies.
package bdeq_pkg;

    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 7;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_WAIT,
        ST_LIST_WAIT,
        ST_RESP,
        ST_LIST_RESP
    } state_t;

    typedef struct packed {
        logic    load_req;
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    list_start;
        logic    list_next;
        logic    load_out;
        logic    out_use_mem;
        logic    out_last;
        status_t out_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             empty;
        logic             full;
        logic             list_last;
        logic             out_last;
    } dp_sts_t;

endpackage

// ===== hdl/bounded_double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// Top level of the bounded deque: sequencer plus ring-store datapath.
// Depends on bdeq_pkg, bdeq_ctrl and bdeq_dpath.
// A bounded double-ended queue of signed values in a ring store of DEPTH
// entries. One request is handled at a time; the next request is taken only
// once the last result beat of the one before has been taken. A push, a refused
// push, an empty pop or list and an unused code are decoded and then give their
// result beat; a pop puts the registered store read between the two. A list of
// N elements gives N beats, each element being one store read followed by its
// beat. Stalls on the result side hold back the result and the next request.
module bounded_double_ended_queue_unit
    import bdeq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [REQ_W-1:0]          req_type,
    input  logic signed [VALUE_W-1:0] push_value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STAT_W-1:0]         status,
    output logic signed [VALUE_W-1:0] data_value,
    output logic [TOTAL_W-1:0]        element_total,
    output logic                      last_of_run
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    bdeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bdeq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req_type),
        .push_value    (push_value),
        .status        (status),
        .data_value    (data_value),
        .element_total (element_total),
        .last_of_run   (last_of_run)
    );

endmodule

// ===== hdl/bdeq_ctrl.sv =====
`timescale 1ns / 1ps
// Request sequencer for the bounded deque unit.
// Depends on bdeq_pkg; drives bdeq_dpath through ctl_cmd_t.
module bdeq_ctrl
    import bdeq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.req)
                    REQ_POP_FRONT, REQ_POP_BACK:
                        state_next = sts.empty ? ST_RESP : ST_POP_WAIT;
                    REQ_LIST:
                        state_next = sts.empty ? ST_RESP : ST_LIST_WAIT;
                    default:
                        state_next = ST_RESP;
                endcase
            end
            ST_POP_WAIT:  state_next = ST_RESP;
            ST_LIST_WAIT: state_next = ST_LIST_RESP;
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = sts.out_last ? ST_IDLE : ST_LIST_WAIT;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.out_status = STAT_OK;
        cmd.out_last   = 1'b1;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            ST_DECODE:
            begin
                case (sts.req)
                    REQ_PUSH_FRONT, REQ_PUSH_BACK:
                    begin
                        cmd.load_out = 1'b1;
                        if (sts.full)
                        begin
                            cmd.out_status = STAT_FULL;
                        end
                        else
                        begin
                            cmd.push_front = (sts.req == REQ_PUSH_FRONT);
                            cmd.push_back  = (sts.req == REQ_PUSH_BACK);
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK:
                    begin
                        if (sts.empty)
                        begin
                            cmd.load_out   = 1'b1;
                            cmd.out_status = STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.pop_front = (sts.req == REQ_POP_FRONT);
                            cmd.pop_back  = (sts.req == REQ_POP_BACK);
                        end
                    end
                    REQ_LIST:
                    begin
                        if (sts.empty)
                        begin
                            cmd.load_out   = 1'b1;
                            cmd.out_status = STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.list_start = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.load_out = 1'b1;
                    end
                endcase
            end
            ST_POP_WAIT:
            begin
                cmd.load_out    = 1'b1;
                cmd.out_use_mem = 1'b1;
            end
            ST_LIST_WAIT:
            begin
                cmd.load_out    = 1'b1;
                cmd.out_use_mem = 1'b1;
                cmd.out_last    = sts.list_last;
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
            end
            ST_LIST_RESP:
            begin
                out_valid     = 1'b1;
                cmd.list_next = out_ready && !sts.out_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/bdeq_dpath.sv =====
`timescale 1ns / 1ps
// Ring store, front index, element count and result register of the deque.
// Depends on bdeq_pkg; controlled by bdeq_ctrl.
module bdeq_dpath
    import bdeq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_cmd_t           cmd,
    output dp_sts_t            sts,
    input  logic [REQ_W-1:0]   req_type,
    input  logic signed [VALUE_W-1:0] push_value,
    output logic [STAT_W-1:0]  status,
    output logic signed [VALUE_W-1:0] data_value,
    output logic [TOTAL_W-1:0] element_total,
    output logic               last_of_run
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [REQ_W-1:0]      req_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [IDX_W-1:0]      front_reg;
    logic [IDX_W-1:0]      front_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    status_t               status_reg;
    logic [VALUE_W-1:0]    data_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic                  last_reg;

    logic [DATA_WIDTH-1:0] wr_data;
    logic [VALUE_W-1:0]    rd_field;
    logic [IDX_W-1:0]      front_dec;
    logic [IDX_W-1:0]      front_inc;
    logic [IDX_W-1:0]      back_pos;
    logic [IDX_W-1:0]      tail_pos;
    logic [IDX_W-1:0]      list_pos;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic                  rd_en;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(offs);
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    generate
        if (DATA_WIDTH > VALUE_W)
        begin : g_wide
            assign wr_data  = {{(DATA_WIDTH-VALUE_W){value_reg[VALUE_W-1]}}, value_reg};
            assign rd_field = rd_data_reg[VALUE_W-1:0];
        end
        else if (DATA_WIDTH == VALUE_W)
        begin : g_same
            assign wr_data  = value_reg;
            assign rd_field = rd_data_reg;
        end
        else
        begin : g_narrow
            assign wr_data  = value_reg[DATA_WIDTH-1:0];
            assign rd_field = {{(VALUE_W-DATA_WIDTH){rd_data_reg[DATA_WIDTH-1]}},
                               rd_data_reg};
        end
    endgenerate

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign tail_pos  = ring_add(front_reg, count_reg);
    assign back_pos  = ring_add(front_reg, count_reg - 1'b1);
    assign list_pos  = ring_add(front_reg, CNT_W'(idx_next));

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.list_start)
        begin
            idx_next = '0;
        end
        else if (cmd.list_next)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (cmd.push_front)
        begin
            front_next = front_dec;
            count_next = count_reg + 1'b1;
        end
        else if (cmd.push_back)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop_front)
        begin
            front_next = front_inc;
            count_next = count_reg - 1'b1;
        end
        else if (cmd.pop_back)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign wr_en   = cmd.push_front || cmd.push_back;
    assign wr_addr = cmd.push_front ? front_dec : tail_pos;
    assign rd_en   = cmd.pop_front || cmd.pop_back || cmd.list_start || cmd.list_next;
    assign rd_addr = cmd.pop_front ? front_reg : (cmd.pop_back ? back_pos : list_pos);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg   <= req_type;
            value_reg <= push_value;
        end
        if (cmd.load_out)
        begin
            status_reg <= cmd.out_status;
            data_reg   <= cmd.out_use_mem ? rd_field : '0;
            total_reg  <= TOTAL_W'(count_next);
            last_reg   <= cmd.out_last;
        end
    end

    assign sts.req       = req_reg;
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CNT_W'(DEPTH));
    assign sts.list_last = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign sts.out_last  = last_reg;

    assign status        = status_reg;
    assign data_value    = data_reg;
    assign element_total = total_reg;
    assign last_of_run   = last_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_front || cmd.push_back) |-> !sts.full)
        else $error("push into a full store");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_front || cmd.pop_back || cmd.list_start) |-> !sts.empty)
        else $error("read from an empty store");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop_front || cmd.pop_back) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not shrink the count");

    a_list_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_next |-> (CNT_W'(idx_reg) + 1'b1) < count_reg)
        else $error("list step past the back element");

endmodule
